// File: rtl/core/arpr_pkg.sv
package arpr_pkg;

	// Bytes kept of each frame and bytes in a reply
	localparam logic [5:0] FRAME_LEN = 6'd42;
	localparam logic [5:0] REPLY_LAST = 6'd41;

	// Header checks run one entry at a time
	localparam logic [2:0] CHK_LAST = 3'd7;

	// Field offsets within a frame
	localparam logic [5:0] OFS_SRC_MAC = 6'd6;
	localparam logic [5:0] OFS_ETYPE = 6'd12;
	localparam logic [5:0] OFS_OPCODE = 6'd20;
	localparam logic [5:0] OFS_SPA = 6'd28;
	localparam logic [5:0] OFS_TPA = 6'd38;

	// Constants of the header
	localparam logic [7:0] ETYPE_HI = 8'h08;
	localparam logic [7:0] ETYPE_LO = 8'h06;
	localparam logic [7:0] OPC_HI = 8'h00;
	localparam logic [7:0] OPC_REQ = 8'h01;
	localparam logic [7:0] OPC_REPLY = 8'h02;

	// Where the shared byte selector takes its byte from
	typedef enum logic [1:0] {
		SRC_MEM = 2'd0,
		SRC_MAC = 2'd1,
		SRC_IP  = 2'd2,
		SRC_LIT = 2'd3
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [5:0] addr;  // frame store entry to read
		logic [2:0] oct;   // octet of own MAC or own IP, first sent is 0
		logic [7:0] lit;
	} sel_t;

	// Frame store write and read requests
	typedef struct packed {
		logic       we;
		logic [5:0] waddr;
		logic [7:0] wdata;
		logic       re;
		logic [5:0] raddr;
	} store_ctl_t;

	// Source of reply byte i
	function automatic sel_t reply_sel(input logic [5:0] i);
		sel_t s;
		s.src = SRC_MEM;
		s.addr = i;
		s.oct = 3'd0;
		s.lit = 8'h00;
		if (i < 6'd6) begin
			s.addr = OFS_SRC_MAC + i;
		end else if (i < 6'd12) begin
			s.src = SRC_MAC;
			s.oct = 3'(i - 6'd6);
		end else if (i < 6'd21) begin
			s.addr = i;
		end else if (i == 6'd21) begin
			s.src = SRC_LIT;
			s.lit = OPC_REPLY;
		end else if (i < 6'd28) begin
			s.src = SRC_MAC;
			s.oct = 3'(i - 6'd22);
		end else if (i < 6'd32) begin
			s.src = SRC_IP;
			s.oct = 3'(i - 6'd28);
		end else if (i < 6'd38) begin
			s.addr = OFS_SRC_MAC + (i - 6'd32);
		end else begin
			s.addr = OFS_SPA + (i - 6'd38);
		end
		return s;
	endfunction

	// Entry and expected value of header check k
	function automatic sel_t chk_sel(input logic [2:0] k);
		sel_t s;
		s.src = SRC_LIT;
		s.addr = OFS_ETYPE;
		s.oct = 3'd0;
		s.lit = ETYPE_HI;
		case (k)
			3'd0: begin
				s.addr = OFS_ETYPE;
				s.lit = ETYPE_HI;
			end
			3'd1: begin
				s.addr = OFS_ETYPE + 6'd1;
				s.lit = ETYPE_LO;
			end
			3'd2: begin
				s.addr = OFS_OPCODE;
				s.lit = OPC_HI;
			end
			3'd3: begin
				s.addr = OFS_OPCODE + 6'd1;
				s.lit = OPC_REQ;
			end
			default: begin
				s.src = SRC_IP;
				s.addr = OFS_TPA + {4'd0, k[1:0]};
				s.oct = {1'b0, k[1:0]};
			end
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/arpr_store.sv
module arpr_store (
	input  logic                    clk,
	input  arpr_pkg::store_ctl_t    ctl,
	output logic [7:0]              rdata
);
	import arpr_pkg::*;

	logic [7:0] mem_q [FRAME_LEN];
	logic [7:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[ctl.waddr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem_q[ctl.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/arpr_engine.sv
module arpr_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [47:0]             own_mac,
	input  logic [31:0]             own_ip,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,
	input  logic                    s_tlast,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,
	output logic                    m_tlast,
	output arpr_pkg::store_ctl_t    store_ctl,
	input  logic [7:0]              store_rdata
);
	import arpr_pkg::*;

	typedef enum logic [4:0] {
		ST_RX      = 5'b00001,
		ST_CHK_RD  = 5'b00010,
		ST_CHK_CMP = 5'b00100,
		ST_TX_RD   = 5'b01000,
		ST_TX_LD   = 5'b10000
	} state_t;

	state_t     state_q;
	logic [5:0] count_q;
	logic [5:0] step_q;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       rx_acc;
	logic [5:0] count_inc;
	logic       frame_full;
	logic       in_chk;
	sel_t       sel;
	logic [7:0] sel_byte;
	logic [7:0] mac_oct;
	logic [7:0] ip_oct;
	logic       out_free;
	logic       out_load;

	assign s_tready = (state_q == ST_RX);
	assign rx_acc = s_tvalid && s_tready;

	// Byte count saturates once the store is full
	assign count_inc = count_q + 6'(count_q < FRAME_LEN);
	assign frame_full = (count_inc == FRAME_LEN);

	// Shared byte selector, serves both the checks and the reply
	assign in_chk = (state_q == ST_CHK_RD) || (state_q == ST_CHK_CMP);
	assign sel = in_chk ? chk_sel(step_q[2:0]) : reply_sel(step_q);

	always_comb begin
		case (sel.oct)
			3'd0:    mac_oct = own_mac[47:40];
			3'd1:    mac_oct = own_mac[39:32];
			3'd2:    mac_oct = own_mac[31:24];
			3'd3:    mac_oct = own_mac[23:16];
			3'd4:    mac_oct = own_mac[15:8];
			3'd5:    mac_oct = own_mac[7:0];
			default: mac_oct = 8'h00;
		endcase
		case (sel.oct[1:0])
			2'd0:    ip_oct = own_ip[31:24];
			2'd1:    ip_oct = own_ip[23:16];
			2'd2:    ip_oct = own_ip[15:8];
			default: ip_oct = own_ip[7:0];
		endcase
		case (sel.src)
			SRC_MEM: sel_byte = store_rdata;
			SRC_MAC: sel_byte = mac_oct;
			SRC_IP:  sel_byte = ip_oct;
			default: sel_byte = sel.lit;
		endcase
	end

	// Frame store requests
	always_comb begin
		store_ctl.we = rx_acc && (count_q < FRAME_LEN);
		store_ctl.waddr = count_q;
		store_ctl.wdata = s_tdata;
		store_ctl.re = (state_q == ST_CHK_RD) || (state_q == ST_TX_RD);
		store_ctl.raddr = sel.addr;
	end

	// Output register
	assign out_free = !out_vld_q || m_tready;
	assign out_load = (state_q == ST_TX_LD) && out_free;

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_last_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= sel_byte;
			out_last_q <= (step_q == REPLY_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Sequencer: receive, check header, send reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RX;
			count_q <= 6'd0;
			step_q <= 6'd0;
		end else begin
			unique case (state_q)
				ST_RX: begin
					if (rx_acc) begin
						if (s_tlast) begin
							count_q <= 6'd0;
							step_q <= 6'd0;
							if (frame_full) begin
								state_q <= ST_CHK_RD;
							end
						end else begin
							count_q <= count_inc;
						end
					end
				end
				ST_CHK_RD: begin
					state_q <= ST_CHK_CMP;
				end
				ST_CHK_CMP: begin
					if (store_rdata != sel_byte) begin
						state_q <= ST_RX;
					end else if (step_q[2:0] == CHK_LAST) begin
						step_q <= 6'd0;
						state_q <= ST_TX_RD;
					end else begin
						step_q <= step_q + 6'd1;
						state_q <= ST_CHK_RD;
					end
				end
				ST_TX_RD: begin
					state_q <= ST_TX_LD;
				end
				ST_TX_LD: begin
					if (out_free) begin
						if (step_q == REPLY_LAST) begin
							state_q <= ST_RX;
						end else begin
							step_q <= step_q + 6'd1;
							state_q <= ST_TX_RD;
						end
					end
				end
				default: begin
					state_q <= ST_RX;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/arp_request_responder.sv
// channel   | dir | signals                               | payload
// ----------+-----+---------------------------------------+---------------------------
// s (rx)    | in  | s_tvalid s_tready s_tdata s_tlast     | rx_byte, rx_last in tlast
// m (tx)    | out | m_tvalid m_tready m_tdata m_tlast     | tx_byte, tx_last in tlast
// cfg       | in  | cfg_we cfg_index cfg_data             | own_mac (0), own_ip (1)
//
// Received bytes are taken one per cycle while s_tready is high; the first 42 go to a one-write,
// one-read store. After a last byte that closes a frame of 42 bytes or more, s_tready drops while
// the shared compare checks 8 header entries, each in a read then a compare state (first mismatch
// ends it), then the reply leaves one byte per read and load state pair through the store's read
// port, any m_tready stall waiting in the load state. A stall only holds the sequencer.
// Reset clears the sequencer, byte count, output valid and both registers.
module arp_request_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // tx_byte
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);
	import arpr_pkg::*;

	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP = 1'b1;

	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	store_ctl_t  store_ctl;
	logic [7:0]  store_rdata;

	// Station address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= 48'd0;
			own_ip_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OWN_MAC: own_mac_q <= cfg_data;
				REG_OWN_IP:  own_ip_q <= cfg_data[31:0];
				default:     own_mac_q <= own_mac_q;
			endcase
		end
	end

	arpr_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_mac     (own_mac_q),
		.own_ip      (own_ip_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.store_ctl   (store_ctl),
		.store_rdata (store_rdata)
	);

	arpr_store u_store (
		.clk   (clk),
		.ctl   (store_ctl),
		.rdata (store_rdata)
	);

endmodule

// File: tb/arp_tb_pkg.sv
package arp_tb_pkg;

	// Register indexes on the configuration port
	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_OWN_IP = 1'b1;

endpackage

// File: tb/arp_checker.sv
module arp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // tx_byte
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	output int          errors,
	output int          pending
);
	import arpr_pkg::*;
	import arp_tb_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_item_t;

	// Predicted state of the responder
	logic [47:0] station_mac;
	logic [31:0] station_ip;
	logic [5:0]  rx_count;
	logic [7:0]  hdr_bytes [0:41];
	reply_item_t reply_q [$];
	int          fail_count = 0;
	int          tx_index = 0;

	assign errors = fail_count;

	function automatic logic [7:0] mac_octet(input int k);
		return station_mac[47 - 8 * k -: 8];
	endfunction

	function automatic logic [7:0] ip_octet(input int k);
		return station_ip[31 - 8 * k -: 8];
	endfunction

	// EtherType ARP, opcode request (both bytes), target IP is ours
	function automatic logic request_for_station();
		if (hdr_bytes[OFS_ETYPE] != ETYPE_HI || hdr_bytes[OFS_ETYPE + 1] != ETYPE_LO)
			return 1'b0;
		if (hdr_bytes[OFS_OPCODE] != OPC_HI || hdr_bytes[OFS_OPCODE + 1] != OPC_REQ)
			return 1'b0;
		for (int k = 0; k < 4; k++)
			if (hdr_bytes[OFS_TPA + k] != ip_octet(k))
				return 1'b0;
		return 1'b1;
	endfunction

	// Reply byte i in wire order
	function automatic logic [7:0] reply_octet(input int i);
		if (i < 6)
			return hdr_bytes[OFS_SRC_MAC + i];       // dest = requester MAC
		if (i < 12)
			return mac_octet(i - 6);                 // source = own MAC
		if (i < 21)
			return hdr_bytes[i];                     // type, htype..opcode hi
		if (i == 21)
			return OPC_REPLY;
		if (i < 28)
			return mac_octet(i - 22);                // sender HW address
		if (i < 32)
			return ip_octet(i - 28);                 // sender IP
		if (i < 38)
			return hdr_bytes[OFS_SRC_MAC + i - 32];  // target HW address
		return hdr_bytes[OFS_SPA + i - 38];          // target IP
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reply_item_t item;
		if (!arst_n) begin
			station_mac = '0;
			station_ip = '0;
			rx_count = '0;
			reply_q.delete();
			pending <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				if (cfg_index == REG_OWN_MAC)
					station_mac = cfg_data;
				else if (cfg_index == REG_OWN_IP)
					station_ip = cfg_data[31:0];
			end

			// rx item: keep the first 42 bytes, judge the frame on its last byte
			if (s_tvalid && s_tready) begin
				if (rx_count < FRAME_LEN) begin
					hdr_bytes[rx_count] = s_tdata;
					rx_count = rx_count + 6'd1;
				end
				if (s_tlast) begin
					if (rx_count == FRAME_LEN && request_for_station()) begin
						for (int i = 0; i < FRAME_LEN; i++) begin
							item.data = reply_octet(i);
							item.last = (i == REPLY_LAST);
							reply_q.push_back(item);
						end
					end
					rx_count = '0;
				end
			end

			// tx item against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					fail_count++;
					$display("%0t: tx item, none expected: got byte %02h last %0b",
						$time, m_tdata, m_tlast);
				end else begin
					item = reply_q.pop_front();
					if (m_tdata !== item.data) begin
						fail_count++;
						$display("%0t: reply byte %0d: expected %02h, got %02h",
							$time, tx_index, item.data, m_tdata);
					end
					if (m_tlast !== item.last) begin
						fail_count++;
						$display("%0t: reply byte %0d: expected last %0b, got %0b",
							$time, tx_index, item.last, m_tlast);
					end
				end
				tx_index = (m_tlast === 1'b1) ? 0 : tx_index + 1;
			end
			pending <= reply_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top;
	import arpr_pkg::*;
	import arp_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;   // header check of a frame with no reply
	localparam int RANDOM_BYTES = 32;
	localparam int MAX_FRAME = 64;

	typedef enum {
		FR_REQUEST,
		FR_BAD_ETYPE_HI,
		FR_BAD_ETYPE_LO,
		FR_BAD_OPC_HI,
		FR_BAD_OPC_LO,
		FR_BAD_TPA,
		FR_NOISE,
		FR_ZEROS,
		FR_ONES
	} frame_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // rx_byte
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // tx_byte
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_OWN_MAC;
	logic [47:0] cfg_data = '0;
	int          errors;
	int          pending;

	logic [31:0] target_ip = '0;
	logic [7:0]  frame [0:MAX_FRAME-1];
	logic        calm = 1'b0;
	int          stall_left = 0;
	int          cycle_count = 0;

	arp_request_responder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	arp_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Idle length: mostly none or short, now and then long; none while calm
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver stalls on the tx side
	always @(posedge clk) begin : tx_stall
		int n;
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			n = gap_len();
			m_tready <= (n == 0);
			stall_left <= (n == 0) ? 0 : n - 1;
		end
	end

	task automatic push_byte(input logic [7:0] value, input logic last);
		int pause;
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pause = gap_len();
		if (pause != 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
	endtask

	// Both registers, back to back; upper data bits of own_ip are noise
	task automatic load_station(input logic [47:0] mac, input logic [47:0] ip_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_OWN_MAC;
		cfg_data <= mac;
		@(posedge clk);
		cfg_index <= REG_OWN_IP;
		cfg_data <= ip_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		target_ip = ip_word[31:0];
	endtask

	// Wait for every reply, then for the header check of a frame without one
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A well-formed request for target_ip, one with a single header field spoilt, or noise, zeros or ones
	task automatic send_frame(input frame_kind_t kind, input int len);
		logic [7:0] flip;
		flip = 8'($urandom_range(1, 255));
		for (int i = 0; i < MAX_FRAME; i++)
			frame[i] = (kind == FR_ZEROS) ? 8'h00 : (kind == FR_ONES) ? 8'hff : 8'($urandom);
		if (kind != FR_NOISE && kind != FR_ZEROS && kind != FR_ONES) begin
			frame[OFS_ETYPE] = ETYPE_HI;
			frame[OFS_ETYPE + 1] = ETYPE_LO;
			frame[OFS_OPCODE] = OPC_HI;
			frame[OFS_OPCODE + 1] = OPC_REQ;
			for (int k = 0; k < 4; k++)
				frame[OFS_TPA + k] = target_ip[31 - 8 * k -: 8];
			case (kind)
				FR_BAD_ETYPE_HI: frame[OFS_ETYPE] ^= flip;
				FR_BAD_ETYPE_LO: frame[OFS_ETYPE + 1] ^= flip;
				FR_BAD_OPC_HI:   frame[OFS_OPCODE] ^= flip;
				FR_BAD_OPC_LO:   frame[OFS_OPCODE + 1] ^= flip;
				FR_BAD_TPA:      frame[OFS_TPA + $urandom_range(0, 3)] ^= flip;
				default: ;
			endcase
		end
		calm = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < len; i++)
			push_byte(frame[i], i == len - 1);
	endtask

	initial begin
		int phase_bytes;
		int len;
		int r;
		frame_kind_t kind;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-zero station, short, exact and spoilt frames
		load_station('0, '0);
		send_frame(FR_REQUEST, FRAME_LEN);
		send_frame(FR_ZEROS, FRAME_LEN);
		send_frame(FR_REQUEST, 1);
		send_frame(FR_REQUEST, FRAME_LEN - 1);
		send_frame(FR_BAD_ETYPE_HI, FRAME_LEN);
		send_frame(FR_BAD_ETYPE_LO, FRAME_LEN);
		send_frame(FR_BAD_OPC_HI, FRAME_LEN);
		send_frame(FR_BAD_OPC_LO, FRAME_LEN);
		send_frame(FR_BAD_TPA, FRAME_LEN);
		wait_drained();

		// Directed: all-ones station, exact and long frames
		load_station('1, '1);
		send_frame(FR_REQUEST, FRAME_LEN);
		send_frame(FR_ONES, FRAME_LEN);
		send_frame(FR_REQUEST, 50);
		wait_drained();

		// Random frames under a random station address
		load_station({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
		phase_bytes = 0;
		while (phase_bytes < RANDOM_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				kind = FR_REQUEST;
			else if (r < 85)
				kind = frame_kind_t'($urandom_range(FR_BAD_ETYPE_HI, FR_BAD_TPA));
			else
				kind = FR_NOISE;
			r = $urandom_range(0, 99);
			if (kind == FR_NOISE)
				len = $urandom_range(1, MAX_FRAME);
			else if (r < 80)
				len = FRAME_LEN;
			else if (r < 92)
				len = $urandom_range(FRAME_LEN + 1, MAX_FRAME);
			else
				len = $urandom_range(1, FRAME_LEN - 1);
			send_frame(kind, len);
			phase_bytes += len;
		end
		wait_drained();

		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
